>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on the same edge, off while in reset.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication on the next edge, off while in reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mlkl_pkg.sv
// Package: types, codes, keyword automaton and saturation helpers of the lexer.
package mlkl_pkg;

  localparam int POSITION_BITS = 16;
  localparam int FIELD_BITS    = 16;
  localparam int KW_BITS       = 5;
  localparam int MODE_BITS     = 2;
  localparam int MAX_TOKENS    = 3;

  // Scan modes
  localparam logic [MODE_BITS-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_IDENT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_PAREN = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_ERROR = 2'd3;

  // Token kinds
  localparam logic [3:0] K_EOF   = 4'd0;
  localparam logic [3:0] K_IDENT = 4'd1;
  localparam logic [3:0] K_AND   = 4'd2;
  localparam logic [3:0] K_FALSE = 4'd3;
  localparam logic [3:0] K_IN    = 4'd4;
  localparam logic [3:0] K_LET   = 4'd5;
  localparam logic [3:0] K_REC   = 4'd6;
  localparam logic [3:0] K_TRUE  = 4'd7;
  localparam logic [3:0] K_UNIT  = 4'd8;
  localparam logic [3:0] K_EQUAL = 4'd9;
  localparam logic [3:0] K_ERROR = 4'd10;

  // Keyword automaton states
  localparam logic [KW_BITS-1:0] KW_ROOT = 5'd0;
  localparam logic [KW_BITS-1:0] KW_DEAD = 5'd31;

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } mlkl_in_t;

  typedef struct packed {
    logic [3:0]            token_kind;
    logic [FIELD_BITS-1:0] token_start;
    logic [FIELD_BITS-1:0] token_length;
    logic                  result_last;
  } mlkl_tok_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] scan_mode;
    pos_t                 byte_position;
    pos_t                 lexeme_start;
    pos_t                 lexeme_length;
    logic [KW_BITS-1:0]   kw_state;
  } mlkl_state_t;

  localparam mlkl_state_t STATE_RESET = '{MODE_IDLE, '0, '0, '0, KW_ROOT};

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  function automatic logic [FIELD_BITS-1:0] sat_field(input pos_t v);
    if ((v >> FIELD_BITS) != '0) return '1;
    return FIELD_BITS'(v);
  endfunction

  // Advance the keyword automaton by one character.
  function automatic logic [KW_BITS-1:0] kw_next(input logic [KW_BITS-1:0] s,
                                                input logic [7:0] c);
    logic [KW_BITS-1:0] r;
    r = KW_DEAD;
    unique case (s)
      5'd0: begin
        if (c == "a") r = 5'd1;
        else if (c == "f") r = 5'd4;
        else if (c == "i") r = 5'd9;
        else if (c == "l") r = 5'd11;
        else if (c == "r") r = 5'd14;
        else if (c == "t") r = 5'd17;
        else if (c == "u") r = 5'd21;
      end
      5'd1:  if (c == "n") r = 5'd2;
      5'd2:  if (c == "d") r = 5'd3;
      5'd4:  if (c == "a") r = 5'd5;
      5'd5:  if (c == "l") r = 5'd6;
      5'd6:  if (c == "s") r = 5'd7;
      5'd7:  if (c == "e") r = 5'd8;
      5'd9:  if (c == "n") r = 5'd10;
      5'd11: if (c == "e") r = 5'd12;
      5'd12: if (c == "t") r = 5'd13;
      5'd14: if (c == "e") r = 5'd15;
      5'd15: if (c == "c") r = 5'd16;
      5'd17: if (c == "r") r = 5'd18;
      5'd18: if (c == "u") r = 5'd19;
      5'd19: if (c == "e") r = 5'd20;
      5'd21: if (c == "n") r = 5'd22;
      5'd22: if (c == "i") r = 5'd23;
      5'd23: if (c == "t") r = 5'd24;
      default: r = KW_DEAD;
    endcase
    return r;
  endfunction

  // Map a final automaton state to a token kind.
  function automatic logic [3:0] kw_kind(input logic [KW_BITS-1:0] s);
    logic [3:0] k;
    unique case (s)
      5'd3:    k = K_AND;
      5'd8:    k = K_FALSE;
      5'd10:   k = K_IN;
      5'd13:   k = K_LET;
      5'd16:   k = K_REC;
      5'd20:   k = K_TRUE;
      5'd24:   k = K_UNIT;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

>>> hw/rtl/mlkl_step.sv
// Next-state and token logic for one input word of the lexer.
module mlkl_step (
  input  mlkl_pkg::mlkl_state_t cur_st,
  input  mlkl_pkg::mlkl_in_t    in_word,
  output mlkl_pkg::mlkl_state_t nxt_st,
  output mlkl_pkg::mlkl_tok_t   toks [mlkl_pkg::MAX_TOKENS],
  output logic [1:0]            tok_cnt
);
  import mlkl_pkg::*;

  function automatic mlkl_tok_t mk_tok(input logic [3:0] k, input pos_t s, input pos_t l);
    mlkl_tok_t t;
    t.token_kind   = k;
    t.token_start  = sat_field(s);
    t.token_length = sat_field(l);
    t.result_last  = 1'b0;
    return t;
  endfunction

  logic [7:0]  c;
  pos_t        p;
  logic        is_space;
  logic        is_start;
  logic        is_cont;
  logic        open_tok;
  mlkl_state_t st;
  logic [1:0]  n;

  assign c = in_word.text_byte;
  assign p = cur_st.byte_position;
  assign is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
  assign is_start = (c >= "a" && c <= "z") || c == "_";
  assign is_cont  = is_start || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")
                    || c == "'";

  always_comb begin
    st       = cur_st;
    n        = 2'd0;
    open_tok = 1'b0;
    for (int i = 0; i < MAX_TOKENS; i++) toks[i] = '0;

    // extend or close a running identifier
    if (st.scan_mode == MODE_IDENT) begin
      if (is_cont) begin
        st.lexeme_length = sat_inc(st.lexeme_length);
        st.kw_state      = kw_next(st.kw_state, c);
      end else begin
        toks[n] = mk_tok(kw_kind(st.kw_state), st.lexeme_start, st.lexeme_length);
        n = n + 2'd1;
        st.scan_mode = MODE_IDLE;
      end
    end

    // handle a byte after '(' or between tokens
    if (st.scan_mode == MODE_PAREN) begin
      if (c == ")") begin
        toks[n] = mk_tok(K_UNIT, st.lexeme_start, pos_t'(2));
        n = n + 2'd1;
        st.scan_mode = MODE_IDLE;
      end else begin
        open_tok = 1'b1;
      end
    end else if (st.scan_mode == MODE_IDLE) begin
      if (c == "(") begin
        st.scan_mode    = MODE_PAREN;
        st.lexeme_start = p;
      end else if (!is_space) begin
        open_tok = 1'b1;
      end
    end

    // open a token: equal, identifier or error
    if (open_tok) begin
      if (c == "=") begin
        toks[n] = mk_tok(K_EQUAL, p, pos_t'(1));
        n = n + 2'd1;
        st.scan_mode = MODE_IDLE;
      end else if (is_start) begin
        st.scan_mode     = MODE_IDENT;
        st.lexeme_start  = p;
        st.lexeme_length = pos_t'(1);
        st.kw_state      = kw_next(KW_ROOT, c);
      end else begin
        toks[n] = mk_tok(K_ERROR, p, pos_t'(1));
        n = n + 2'd1;
        st.scan_mode = MODE_ERROR;
      end
    end

    st.byte_position = sat_inc(p);

    // flush at end of text, then return to reset state
    if (in_word.end_of_text) begin
      if (st.scan_mode == MODE_IDENT) begin
        toks[n] = mk_tok(kw_kind(st.kw_state), st.lexeme_start, st.lexeme_length);
        n = n + 2'd1;
      end
      toks[n] = mk_tok(K_EOF, st.byte_position, '0);
      n = n + 2'd1;
      st = STATE_RESET;
    end

    // flag the final token of this word
    if (n != 2'd0) toks[n - 2'd1].result_last = 1'b1;
  end

  assign nxt_st  = st;
  assign tok_cnt = n;

endmodule

>>> hw/rtl/mlkl_tok_fifo.sv
// Token queue: takes up to three words per cycle, gives one unless stalled.
module mlkl_tok_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  mlkl_pkg::mlkl_tok_t push_toks [mlkl_pkg::MAX_TOKENS],
  input  logic [1:0]          push_cnt,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output mlkl_pkg::mlkl_tok_t out_data
);
  import mlkl_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_BITS = $clog2(DEPTH);

  mlkl_tok_t             mem_r [DEPTH];
  logic [PTR_BITS-1:0]   wr_r, wr_nxt;
  logic [PTR_BITS-1:0]   rd_r, rd_nxt;
  logic [PTR_BITS:0]     cnt_r, cnt_nxt;
  logic                  pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  // room for the largest burst one word can cause
  assign room      = (cnt_r <= (PTR_BITS+1)'(DEPTH - MAX_TOKENS));

  assign wr_nxt  = wr_r + PTR_BITS'(push_cnt);
  assign rd_nxt  = rd_r + PTR_BITS'(pop);
  assign cnt_nxt = cnt_r + (PTR_BITS+1)'(push_cnt) - (PTR_BITS+1)'(pop);

  // write the burst into consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (2'(i) < push_cnt) mem_r[wr_r + PTR_BITS'(i)] <= push_toks[i];
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/ml_keyword_lexer_core.sv
// Top level of the keyword and identifier lexer.
//
//   channel | direction | payload     | handshake
//   in_     | input     | mlkl_in_t   | in_valid / in_stall
//   out_    | output    | mlkl_tok_t  | out_valid / out_stall
//
// One byte is taken per cycle while in_stall is low; its tokens are
// written to a four-word queue in the same cycle and leave it one per
// cycle while out_stall is low. A byte that causes two or three tokens
// can hold in_stall while the queue drains; the queue fill count sets
// in_stall. Reset (rst_n low, synchronous) returns the scanner to
// position 0 and empties the queue. out_stall only fills the queue;
// in_stall does not depend on in_valid or combinationally on out_stall.
module ml_keyword_lexer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mlkl_pkg::mlkl_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mlkl_pkg::mlkl_tok_t out_data
);
  import mlkl_pkg::*;

  mlkl_state_t st_r, st_nxt;
  mlkl_state_t step_st;
  mlkl_tok_t   step_toks [MAX_TOKENS];
  logic [1:0]  step_cnt;
  logic [1:0]  push_cnt;
  logic        room;
  logic        take;

  assign in_stall = !room;
  assign take     = in_valid && room;
  assign push_cnt = take ? step_cnt : 2'd0;
  assign st_nxt   = take ? step_st : st_r;

  mlkl_step u_step (
    .cur_st  (st_r),
    .in_word (in_data),
    .nxt_st  (step_st),
    .toks    (step_toks),
    .tok_cnt (step_cnt)
  );

  mlkl_tok_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_toks (step_toks),
    .push_cnt  (push_cnt),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // hold scanner state between words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> hw/rtl/mlkl_checker.sv
// Port-level checker for the lexer core and its bind.
`include "assert_macros.svh"

module mlkl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mlkl_pkg::mlkl_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input mlkl_pkg::mlkl_tok_t out_data
);
  import mlkl_pkg::*;

  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "out word changed while stalled")
  `CHK_SAME(a_eof_shape, out_valid && out_data.token_kind == K_EOF, out_data.token_length == 16'd0 && out_data.result_last, "eof token malformed")
  `CHK_SAME(a_single_len, out_valid && (out_data.token_kind == K_EQUAL || out_data.token_kind == K_ERROR), out_data.token_length == 16'd1, "equal or error length not one")
  `CHK_NEXT(a_eof_restart, in_valid && !in_stall && in_data.end_of_text, out_valid, "no token after end of text")

endmodule

bind ml_keyword_lexer_core mlkl_checker u_mlkl_checker (.*);
